@@ rtl/mcr_pkg.sv @@
// Shared constants and types for the maximum circumradius block.
package mcr_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 16;
   localparam int DIFF_W     = COORD_W + 1;

   // multiplier operand and product widths
   localparam int MUL_IN_W   = 53;
   localparam int MUL_HALF_W = 27;
   localparam int MUL_OUT_W  = 2 * MUL_IN_W - 1;

   localparam int DET_W  = 36;
   localparam int SQ_W   = 35;
   localparam int NUM_W  = 104;
   localparam int DEN_W  = 72;
   localparam int FRAC_W = 16;
   localparam int DIVN_W = NUM_W + FRAC_W;
   localparam int RSQ_W  = 64;
   localparam int RAD_W  = 32;

   // product sequence for one triple
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_XY   = 4'd0;
   localparam logic [OP_W-1:0] OP_YX   = 4'd1;
   localparam logic [OP_W-1:0] OP_XX12 = 4'd2;
   localparam logic [OP_W-1:0] OP_YY12 = 4'd3;
   localparam logic [OP_W-1:0] OP_XX13 = 4'd4;
   localparam logic [OP_W-1:0] OP_YY13 = 4'd5;
   localparam logic [OP_W-1:0] OP_NX_A = 4'd6;
   localparam logic [OP_W-1:0] OP_NX_B = 4'd7;
   localparam logic [OP_W-1:0] OP_NY_A = 4'd8;
   localparam logic [OP_W-1:0] OP_NY_B = 4'd9;
   localparam logic [OP_W-1:0] OP_NN_A = 4'd10;
   localparam logic [OP_W-1:0] OP_NN_B = 4'd11;
   localparam logic [OP_W-1:0] OP_DD   = 4'd12;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

endpackage

@@ rtl/mcr_if.sv @@
// Channel interfaces for points in and results out.
interface mcr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mcr_pkg::COORD_W-1:0]   px;
   logic signed [mcr_pkg::COORD_W-1:0]   py;
   logic                                 last_point;
   modport source (output valid, px, py, last_point, input ready);
   modport sink   (input valid, px, py, last_point, output ready);
endinterface

interface mcr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mcr_pkg::RSQ_W-1:0]     max_radius_sq;
   logic [mcr_pkg::RAD_W-1:0]     max_radius;
   logic                          any_circle;
   modport source (output valid, max_radius_sq, max_radius, any_circle, input ready);
   modport sink   (input valid, max_radius_sq, max_radius, any_circle, output ready);
endinterface

@@ rtl/mcr_store.sv @@
// Point store: one write port, one registered read port.
module mcr_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [mcr_pkg::ADDR_W-1:0]  wr_addr,
   input  mcr_pkg::point_type          wr_data,
   input  logic [mcr_pkg::ADDR_W-1:0]  rd_addr,
   output mcr_pkg::point_type          rd_data
);
   mcr_pkg::point_type mem [mcr_pkg::MAX_POINTS];
   mcr_pkg::point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/mcr_mul.sv @@
// Signed multiplier built from four half-width partial products, one per cycle.
module mcr_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [mcr_pkg::MUL_IN_W-1:0]   a,
   input  logic signed [mcr_pkg::MUL_IN_W-1:0]   b,
   output logic                                  done,
   output logic signed [mcr_pkg::MUL_OUT_W-1:0]  prod
);
   localparam int H = mcr_pkg::MUL_HALF_W;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [2:0]      step_ff, step_in;
   logic [2*H-1:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic            neg_ff, neg_in;
   logic [2*H-1:0]  part_ff, part_in;
   logic [4*H-1:0]  acc_ff, acc_in;
   logic [2:0]      pstep;
   logic [H-1:0]    asel, bsel;
   logic [4*H-1:0]  addend, result;
   logic [mcr_pkg::MUL_IN_W-1:0] a_mag, b_mag;

   always_comb begin
      a_mag = a[mcr_pkg::MUL_IN_W-1] ? mcr_pkg::MUL_IN_W'(-a) : mcr_pkg::MUL_IN_W'(a);
      b_mag = b[mcr_pkg::MUL_IN_W-1] ? mcr_pkg::MUL_IN_W'(-b) : mcr_pkg::MUL_IN_W'(b);
      asel  = step_ff[1] ? ma_ff[2*H-1:H] : ma_ff[H-1:0];
      bsel  = step_ff[0] ? mb_ff[2*H-1:H] : mb_ff[H-1:0];
      pstep = step_ff - 3'd1;
      case (pstep[1:0])
         2'd0:    addend = (4*H)'(part_ff);
         2'd1:    addend = (4*H)'(part_ff) << H;
         2'd2:    addend = (4*H)'(part_ff) << H;
         default: addend = (4*H)'(part_ff) << (2*H);
      endcase

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      part_in = part_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         ma_in   = (2*H)'(a_mag);
         mb_in   = (2*H)'(b_mag);
         neg_in  = a[mcr_pkg::MUL_IN_W-1] ^ b[mcr_pkg::MUL_IN_W-1];
         acc_in  = '0;
      end else if (busy_ff) begin
         if (step_ff != 3'd4) begin
            part_in = asel * bsel;
         end
         if (step_ff != 3'd0) begin
            acc_in = acc_ff + addend;
         end
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      result = neg_ff ? -acc_ff : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      neg_ff  <= neg_in;
      part_ff <= part_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;
   assign prod = $signed(result[mcr_pkg::MUL_OUT_W-1:0]);
endmodule

@@ rtl/mcr_div.sv @@
// Restoring divider, one quotient bit per cycle, saturating to 64 bits.
module mcr_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mcr_pkg::DIVN_W-1:0]     num,
   input  logic [mcr_pkg::DEN_W-1:0]      den,
   output logic                           done,
   output logic [mcr_pkg::RSQ_W-1:0]      quot
);
   localparam int NW = mcr_pkg::DIVN_W;
   localparam int DW = mcr_pkg::DEN_W;
   localparam int CW = $clog2(NW);

   logic                            busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]                   cnt_ff, cnt_in;
   logic [NW-1:0]                   nsh_ff, nsh_in;
   logic [DW-1:0]                   den_ff, den_in, rem_ff, rem_in;
   logic [mcr_pkg::RSQ_W-1:0]       q_ff, q_in;
   logic                            ovf_ff, ovf_in;
   logic [DW:0]                     rem_sh, rem_sub;
   logic                            ge;

   always_comb begin
      rem_sh  = {rem_ff, nsh_ff[NW-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      ge      = rem_sh >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      nsh_in  = nsh_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         nsh_in  = num;
         den_in  = den;
         rem_in  = '0;
         q_in    = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
         q_in   = {q_ff[mcr_pkg::RSQ_W-2:0], ge};
         ovf_in = ovf_ff | q_ff[mcr_pkg::RSQ_W-1];
         nsh_in = nsh_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      nsh_ff <= nsh_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign quot = ovf_ff ? '1 : q_ff;
endmodule

@@ rtl/mcr_sqrt.sv @@
// Integer square root, two radicand bits per cycle.
module mcr_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mcr_pkg::RSQ_W-1:0]   value,
   output logic                        done,
   output logic [mcr_pkg::RAD_W-1:0]   root
);
   localparam int W = mcr_pkg::RSQ_W;

   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W-1:0]  v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [W-1:0]  trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in    = value;
         res_in  = '0;
         bit_in  = W'(1) << (W - 2);
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_in == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[mcr_pkg::RAD_W-1:0];
endmodule

@@ rtl/max_circumradius_of_triples_top.sv @@
// Top level: point store, triple sequencer, shared multiplier, divider and root.
// Each ordinary point is written to the store while idle; the last point starts
//   a sweep of all triples, with 13 products on the shared multiplier plus a divide per
//   non-collinear triple and only the first two products per collinear one.
// One result is returned per point set, at the end of its sweep.
// Reset (synchronous, active high) clears the point count and the running maximum.
module max_circumradius_of_triples_top (
   input  logic     clock,
   input  logic     reset,
   mcr_req_if.sink  req,
   mcr_rsp_if.source rsp
);
   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_RI     = 13'b0000000000010,
      S_RJ     = 13'b0000000000100,
      S_RK     = 13'b0000000001000,
      S_DIFF   = 13'b0000000010000,
      S_MSTART = 13'b0000000100000,
      S_MWAIT  = 13'b0000001000000,
      S_DSTART = 13'b0000010000000,
      S_DWAIT  = 13'b0000100000000,
      S_NEXT   = 13'b0001000000000,
      S_QSTART = 13'b0010000000000,
      S_QWAIT  = 13'b0100000000000,
      S_OUT    = 13'b1000000000000
   } state_type;

   localparam int AW = mcr_pkg::ADDR_W;
   localparam int CW = mcr_pkg::CNT_W;
   localparam int MI = mcr_pkg::MUL_IN_W;
   localparam int MO = mcr_pkg::MUL_OUT_W;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   mcr_pkg::point_type pi_ff, pi_in, pj_ff, pj_in;
   logic signed [mcr_pkg::DIFF_W-1:0] x12_ff, x12_in, y12_ff, y12_in;
   logic signed [mcr_pkg::DIFF_W-1:0] x13_ff, x13_in, y13_ff, y13_in;
   logic [mcr_pkg::OP_W-1:0] op_ff, op_in;
   logic signed [MO-1:0] t0_ff, t0_in;
   logic signed [mcr_pkg::DET_W-1:0] d_ff, d_in;
   logic signed [mcr_pkg::SQ_W-1:0] s2_ff, s2_in, s3_ff, s3_in;
   logic signed [MI-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [mcr_pkg::NUM_W-1:0] num_ff, num_in;
   logic [mcr_pkg::DEN_W-1:0] den_ff, den_in;
   logic [mcr_pkg::RSQ_W-1:0] best_ff, best_in;
   logic found_ff, found_in;
   logic [mcr_pkg::RAD_W-1:0] root_ff, root_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [mcr_pkg::RSQ_W-1:0] rsp_sq_ff, rsp_sq_in;
   logic [mcr_pkg::RAD_W-1:0] rsp_rad_ff, rsp_rad_in;
   logic rsp_any_ff, rsp_any_in;

   logic req_fire, store_room, wr_en;
   logic [CW-1:0] count_next;
   logic [AW-1:0] rd_addr;
   mcr_pkg::point_type rd_data, wr_data;
   logic signed [MI-1:0] mul_a, mul_b;
   logic signed [MO-1:0] mul_p, t0_sum, t0_dif;
   logic mul_done, div_done, sq_done;
   logic [mcr_pkg::RSQ_W-1:0] div_q;
   logic [mcr_pkg::RAD_W-1:0] sq_root;

   assign req.ready  = (state_ff == S_IDLE);
   assign req_fire   = req.valid && req.ready;
   assign store_room = count_ff < CW'(mcr_pkg::MAX_POINTS);
   assign wr_en      = req_fire && store_room;
   assign wr_data    = '{x: req.px, y: req.py};
   assign count_next = store_room ? count_ff + 1'b1 : count_ff;

   always_comb begin
      case (state_ff)
         S_RI:    rd_addr = i_ff;
         S_RJ:    rd_addr = j_ff;
         default: rd_addr = k_ff;
      endcase
   end

   mcr_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      case (op_ff)
         mcr_pkg::OP_XY:   begin mul_a = MI'(x12_ff); mul_b = MI'(y13_ff); end
         mcr_pkg::OP_YX:   begin mul_a = MI'(y12_ff); mul_b = MI'(x13_ff); end
         mcr_pkg::OP_XX12: begin mul_a = MI'(x12_ff); mul_b = MI'(x12_ff); end
         mcr_pkg::OP_YY12: begin mul_a = MI'(y12_ff); mul_b = MI'(y12_ff); end
         mcr_pkg::OP_XX13: begin mul_a = MI'(x13_ff); mul_b = MI'(x13_ff); end
         mcr_pkg::OP_YY13: begin mul_a = MI'(y13_ff); mul_b = MI'(y13_ff); end
         mcr_pkg::OP_NX_A: begin mul_a = MI'(y13_ff); mul_b = MI'(s2_ff); end
         mcr_pkg::OP_NX_B: begin mul_a = MI'(y12_ff); mul_b = MI'(s3_ff); end
         mcr_pkg::OP_NY_A: begin mul_a = MI'(x12_ff); mul_b = MI'(s3_ff); end
         mcr_pkg::OP_NY_B: begin mul_a = MI'(x13_ff); mul_b = MI'(s2_ff); end
         mcr_pkg::OP_NN_A: begin mul_a = nx_ff;       mul_b = nx_ff; end
         mcr_pkg::OP_NN_B: begin mul_a = ny_ff;       mul_b = ny_ff; end
         default:          begin mul_a = MI'(d_ff);   mul_b = MI'(d_ff); end
      endcase
   end

   mcr_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_MSTART),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_p)
   );

   mcr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_DSTART),
      .num   ({num_ff, {mcr_pkg::FRAC_W{1'b0}}}),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   mcr_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_QSTART),
      .value (best_ff),
      .done  (sq_done),
      .root  (sq_root)
   );

   assign t0_sum = t0_ff + mul_p;
   assign t0_dif = t0_ff - mul_p;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      pi_in = pi_ff; pj_in = pj_ff;
      x12_in = x12_ff; y12_in = y12_ff; x13_in = x13_ff; y13_in = y13_ff;
      op_in = op_ff; t0_in = t0_ff; d_in = d_ff;
      s2_in = s2_ff; s3_in = s3_ff; nx_in = nx_ff; ny_in = ny_ff;
      num_in = num_ff; den_in = den_ff;
      best_in = best_ff; found_in = found_ff; root_in = root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_sq_in = rsp_sq_ff; rsp_rad_in = rsp_rad_ff; rsp_any_in = rsp_any_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               count_in = count_next;
               if (req.last_point) begin
                  i_in = AW'(0);
                  j_in = AW'(1);
                  k_in = AW'(2);
                  state_in = (count_next >= CW'(3)) ? S_RI : S_QSTART;
               end
            end
         end
         S_RI: state_in = S_RJ;
         S_RJ: begin
            pi_in = rd_data;
            state_in = S_RK;
         end
         S_RK: begin
            pj_in = rd_data;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            x12_in = mcr_pkg::DIFF_W'(pj_ff.x) - mcr_pkg::DIFF_W'(pi_ff.x);
            y12_in = mcr_pkg::DIFF_W'(pj_ff.y) - mcr_pkg::DIFF_W'(pi_ff.y);
            x13_in = mcr_pkg::DIFF_W'(rd_data.x) - mcr_pkg::DIFF_W'(pi_ff.x);
            y13_in = mcr_pkg::DIFF_W'(rd_data.y) - mcr_pkg::DIFF_W'(pi_ff.y);
            op_in = mcr_pkg::OP_XY;
            state_in = S_MSTART;
         end
         S_MSTART: state_in = S_MWAIT;
         S_MWAIT: begin
            if (mul_done) begin
               op_in = op_ff + 1'b1;
               state_in = S_MSTART;
               case (op_ff)
                  mcr_pkg::OP_YX: begin
                     d_in = $signed({t0_dif[mcr_pkg::DET_W-2:0], 1'b0});
                     // collinear triple: no circle
                     if (t0_ff == mul_p) state_in = S_NEXT;
                  end
                  mcr_pkg::OP_YY12: s2_in = mcr_pkg::SQ_W'(t0_sum);
                  mcr_pkg::OP_YY13: s3_in = mcr_pkg::SQ_W'(t0_sum);
                  mcr_pkg::OP_NX_B: nx_in = MI'(t0_dif);
                  mcr_pkg::OP_NY_B: ny_in = MI'(t0_dif);
                  mcr_pkg::OP_NN_B: num_in = t0_sum[mcr_pkg::NUM_W-1:0];
                  mcr_pkg::OP_DD: begin
                     den_in = mul_p[mcr_pkg::DEN_W-1:0];
                     state_in = S_DSTART;
                  end
                  default: t0_in = mul_p;
               endcase
            end
         end
         S_DSTART: state_in = S_DWAIT;
         S_DWAIT: begin
            if (div_done) begin
               found_in = 1'b1;
               if (div_q > best_ff) best_in = div_q;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            state_in = S_RI;
            if ((CW'(k_ff) + 1'b1) < count_ff) begin
               k_in = k_ff + 1'b1;
            end else if ((CW'(j_ff) + CW'(2)) < count_ff) begin
               j_in = j_ff + 1'b1;
               k_in = j_ff + AW'(2);
            end else if ((CW'(i_ff) + CW'(3)) < count_ff) begin
               i_in = i_ff + 1'b1;
               j_in = i_ff + AW'(2);
               k_in = i_ff + AW'(3);
            end else begin
               state_in = S_QSTART;
            end
         end
         S_QSTART: state_in = S_QWAIT;
         S_QWAIT: begin
            if (sq_done) begin
               root_in = sq_root;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sq_in  = best_ff;
               rsp_rad_in = root_ff;
               rsp_any_in = found_ff;
               count_in = '0;
               best_in  = '0;
               found_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         best_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      pi_ff <= pi_in; pj_ff <= pj_in;
      x12_ff <= x12_in; y12_ff <= y12_in; x13_ff <= x13_in; y13_ff <= y13_in;
      op_ff <= op_in; t0_ff <= t0_in; d_ff <= d_in;
      s2_ff <= s2_in; s3_ff <= s3_in; nx_ff <= nx_in; ny_ff <= ny_in;
      num_ff <= num_in; den_ff <= den_in; root_ff <= root_in;
      rsp_sq_ff <= rsp_sq_in; rsp_rad_ff <= rsp_rad_in; rsp_any_ff <= rsp_any_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.max_radius_sq = rsp_sq_ff;
   assign rsp.max_radius    = rsp_rad_ff;
   assign rsp.any_circle    = rsp_any_ff;

   a_no_circle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.any_circle |-> rsp.max_radius_sq == '0)
      else $error("zero result expected without a circle");

   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ({32'd0, rsp.max_radius} * {32'd0, rsp.max_radius}) <= rsp.max_radius_sq)
      else $error("root exceeds square root of radius");

   a_triple_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RI) |-> (i_ff < j_ff) && (j_ff < k_ff) && (CW'(k_ff) < count_ff))
      else $error("triple indices out of order");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(mcr_pkg::MAX_POINTS))
      else $error("point count past store depth");
endmodule
